// ===== hw/rtl/dlp_pkg.sv =====
`default_nettype none
package dlp_pkg;
  localparam int unsigned MaxNodes = 64;
  localparam int unsigned MaxEdges = 256;
  localparam int unsigned NodeW = 7;
  localparam int unsigned NidxW = $clog2(MaxNodes);
  localparam int unsigned EidxW = $clog2(MaxEdges);
  localparam int unsigned EcntW = EidxW + 1;
  localparam int unsigned WeightW = 32;
  localparam int unsigned DistW = 38;
  // running sums: every stored edge may add its weight once
  localparam int unsigned AccW = DistW + 2;
  localparam int unsigned DegW = EcntW;
  localparam int unsigned QcntW = NidxW + 1;

  localparam logic [0:0] CfgNodeCount = 1'b0;
  localparam logic [0:0] CfgSourceNode = 1'b1;
  localparam logic ModeEdge = 1'b0;
  localparam logic ModeCompute = 1'b1;

  typedef struct packed {
    logic [NodeW-1:0]   tail;
    logic [NodeW-1:0]   head;
    logic [WeightW-1:0] weight;
  } edge_t;
endpackage
`default_nettype wire

// ===== hw/rtl/dlp_edge_ram.sv =====
`default_nettype none
// edge store: one write port, one registered read port
module dlp_edge_ram (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [dlp_pkg::EidxW-1:0]  waddr_i,
  input  wire dlp_pkg::edge_t             wdata_i,
  input  wire logic [dlp_pkg::EidxW-1:0]  raddr_i,
  output      dlp_pkg::edge_t             rdata_o
);
  dlp_pkg::edge_t mem [dlp_pkg::MaxEdges];

  // synchronous write and read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/dag_longest_path.sv =====
`default_nettype none
// channel | direction | handshake               | payload
// in      | input     | in_valid_i/in_ready_o   | mode, from_node, to_node, weight
// out     | output    | out_valid_o/out_ready_i | node_index, reachable, distance,
//         |           |                         |   edges_dropped, last
// cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
// an edge item is taken back to back with the one before it.
// a compute item with n nodes and E stored edges clears the in-degrees, recounts
// them over the edges, scans for zero in-degree nodes, then per ordered node walks
// the edges, in ordering and again in relaxation for each reached node, then emits
// one result per node.
// reset is asynchronous for registers; node and queue memories are not reset.
// input ready is low from a compute transfer until its last result is registered;
// the result walk waits while a result sits in the output register unaccepted.
module dag_longest_path (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic                         mode_i,
  input  wire logic [6:0]                   from_node_i,
  input  wire logic [6:0]                   to_node_i,
  input  wire logic signed [31:0]           weight_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic [6:0]                   node_index_o,
  output      logic                         reachable_o,
  output      logic signed [37:0]           distance_o,
  output      logic                         edges_dropped_o,
  output      logic                         last_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [0:0]                   cfg_index_i,
  input  wire logic [6:0]                   cfg_data_i
);
  localparam int unsigned NW = dlp_pkg::NodeW;
  localparam int unsigned EW = dlp_pkg::EidxW;
  localparam int unsigned CW = dlp_pkg::EcntW;
  localparam int unsigned QW = dlp_pkg::QcntW;
  localparam int unsigned IW = dlp_pkg::NidxW;
  localparam int unsigned DW = dlp_pkg::DistW;
  localparam int unsigned AW = dlp_pkg::AccW;
  localparam int unsigned NN = dlp_pkg::MaxNodes;

  typedef enum logic [3:0] {
    S_LOAD, S_CLR, S_CNT, S_SCAN, S_ORD_NODE, S_ORD_FETCH, S_ORD_EDGE,
    S_REL_NODE, S_REL_FETCH, S_REL_LOAD, S_REL_EDGE, S_EMIT
  } state_e;

  // edge walk: address issued, edge data valid, node data valid
  typedef enum logic [1:0] {
    P_ADDR, P_EDGE, P_NODE
  } phase_e;

  state_e state_q;
  phase_e ph_q;
  logic [NW-1:0] node_count_q, source_node_q;
  logic [CW-1:0] edge_total_q;
  logic overflow_q, dropped_q;
  logic [NW-1:0] n_q;
  logic [CW-1:0] eptr_q;     // edge address in the walk
  logic [NW-1:0] node_q;     // clear / scan / emit index
  logic [QW-1:0] qh_q, qt_q;
  logic [NW-1:0] cur_q;
  logic signed [AW-1:0] cur_dist_q;
  logic [NN-1:0] reach_q;

  // node memory: in-degree while ordering, distance while relaxing
  logic [AW-1:0] node_mem [NN];
  logic [AW-1:0] node_rd_q;
  logic          node_we;
  logic [IW-1:0] node_waddr, node_raddr;
  logic [AW-1:0] node_wdata;
  logic signed [AW-1:0] node_rd_s;

  // order queue memory
  logic [NW-1:0] queue_mem [NN];
  logic [NW-1:0] queue_rd_q;
  logic          queue_we;
  logic [NW-1:0] queue_wdata;
  logic [IW-1:0] queue_raddr;

  // output register
  logic ovalid_q;
  logic [NW-1:0] oidx_q;
  logic oreach_q, olast_q, odrop_q;
  logic signed [DW-1:0] odist_q;

  dlp_pkg::edge_t rd, wr;
  logic we;
  logic nodes_ok;
  logic [EW-1:0] raddr;

  assign in_ready_o = (state_q == S_LOAD);
  assign wr = '{tail: from_node_i, head: to_node_i, weight: weight_i};
  assign nodes_ok = (from_node_i >= 7'd1) && (from_node_i <= 7'(NN))
                    && (to_node_i >= 7'd1) && (to_node_i <= 7'(NN));
  assign we = in_valid_i && in_ready_o && (mode_i == dlp_pkg::ModeEdge) && nodes_ok
              && (edge_total_q < CW'(dlp_pkg::MaxEdges));
  assign raddr = eptr_q[EW-1:0];

  dlp_edge_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (edge_total_q[EW-1:0]),
    .wdata_i (wr),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  // edge from read data lies inside 1..n
  logic rd_in;
  logic edge_own;
  logic [IW-1:0] rh;
  logic [IW-1:0] ci;
  logic signed [AW-1:0] cand;
  logic relax_upd;
  logic walk_more;
  logic src_ok;
  logic emit_load;
  assign rd_in = (rd.tail <= n_q) && (rd.head <= n_q);
  assign edge_own = (rd.tail == cur_q) && (rd.head <= n_q);
  assign rh = IW'(rd.head - 7'd1);
  assign ci = IW'(cur_q - 7'd1);
  assign node_rd_s = $signed(node_rd_q);
  assign cand = cur_dist_q + AW'($signed(rd.weight));
  assign relax_upd = !reach_q[rh] || (cand > node_rd_s);
  assign walk_more = (eptr_q < edge_total_q);
  assign src_ok = (source_node_q >= 7'd1) && (source_node_q <= n_q);
  assign emit_load = (state_q == S_EMIT) && (ph_q == P_NODE)
                     && (!ovalid_q || out_ready_i);

  // memory access control
  always_comb begin
    node_we = 1'b0;
    node_waddr = rh;
    node_wdata = '0;
    node_raddr = rh;
    queue_we = 1'b0;
    queue_wdata = rd.head;
    queue_raddr = qh_q[IW-1:0];
    unique case (state_q)
      S_CLR: begin
        node_we = 1'b1;
        node_waddr = IW'(node_q - 7'd1);
      end
      S_CNT: begin
        if (ph_q == P_NODE) begin
          node_we = 1'b1;
          node_wdata = node_rd_q + AW'(1);
        end
      end
      S_SCAN: begin
        node_raddr = IW'(node_q - 7'd1);
        if (ph_q == P_NODE && node_rd_q == '0) begin
          queue_we = 1'b1;
          queue_wdata = node_q;
        end
      end
      S_ORD_NODE: begin
        if (qh_q == qt_q && src_ok) begin
          node_we = 1'b1;
          node_waddr = IW'(source_node_q - 7'd1);
        end
      end
      S_ORD_EDGE: begin
        if (ph_q == P_NODE && node_rd_q != '0) begin
          node_we = 1'b1;
          node_wdata = node_rd_q - AW'(1);
          if (node_rd_q == AW'(1) && qt_q < QW'(NN)) queue_we = 1'b1;
        end
      end
      S_REL_FETCH: begin
        node_raddr = IW'(queue_rd_q - 7'd1);
      end
      S_REL_EDGE: begin
        if (ph_q == P_NODE && relax_upd) begin
          node_we = 1'b1;
          node_wdata = cand;
        end
      end
      S_EMIT: begin
        node_raddr = IW'(node_q - 7'd1);
      end
      default: begin
      end
    endcase
  end

  // node memory
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rd_q <= node_mem[node_raddr];
  end

  // order queue memory
  always_ff @(posedge clk_i) begin
    if (queue_we) begin
      queue_mem[qt_q[IW-1:0]] <= queue_wdata;
    end
    queue_rd_q <= queue_mem[queue_raddr];
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= 7'd64;
      source_node_q <= 7'd1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == dlp_pkg::CfgNodeCount) node_count_q <= cfg_data_i;
      else source_node_q <= cfg_data_i;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      ph_q <= P_ADDR;
      edge_total_q <= '0;
      overflow_q <= 1'b0;
      dropped_q <= 1'b0;
      n_q <= 7'd1;
      eptr_q <= '0;
      node_q <= 7'd1;
      qh_q <= '0;
      qt_q <= '0;
      cur_q <= 7'd1;
      cur_dist_q <= '0;
      reach_q <= '0;
      ovalid_q <= 1'b0;
      oidx_q <= '0;
      oreach_q <= 1'b0;
      olast_q <= 1'b0;
      odrop_q <= 1'b0;
      odist_q <= '0;
    end else begin
      if (emit_load) begin
        ovalid_q <= 1'b1;
        oidx_q <= node_q;
        oreach_q <= reach_q[IW'(node_q - 7'd1)];
        odist_q <= reach_q[IW'(node_q - 7'd1)] ? node_rd_q[DW-1:0] : '1;
        odrop_q <= dropped_q;
        olast_q <= (node_q == n_q);
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        S_LOAD: begin
          if (in_valid_i) begin
            if (mode_i == dlp_pkg::ModeCompute) begin
              dropped_q <= overflow_q;
              if (node_count_q == 7'd0) n_q <= 7'd1;
              else if (node_count_q > 7'(NN)) n_q <= 7'(NN);
              else n_q <= node_count_q;
              node_q <= 7'd1;
              ph_q <= P_ADDR;
              state_q <= S_CLR;
            end else if (we) begin
              edge_total_q <= edge_total_q + 1'b1;
            end else if (nodes_ok) begin
              overflow_q <= 1'b1;
            end
          end
        end
        // clearing pass over the in-degrees
        S_CLR: begin
          if (node_q == n_q) begin
            eptr_q <= '0;
            ph_q <= P_ADDR;
            state_q <= S_CNT;
          end else begin
            node_q <= node_q + 7'd1;
          end
        end
        // recount in-degrees, read-modify-write per edge
        S_CNT: begin
          unique case (ph_q)
            P_ADDR: begin
              if (walk_more) begin
                ph_q <= P_EDGE;
              end else begin
                node_q <= 7'd1;
                qt_q <= '0;
                qh_q <= '0;
                state_q <= S_SCAN;
              end
            end
            P_EDGE: begin
              if (rd_in) begin
                ph_q <= P_NODE;
              end else begin
                eptr_q <= eptr_q + 1'b1;
                ph_q <= P_ADDR;
              end
            end
            default: begin
              eptr_q <= eptr_q + 1'b1;
              ph_q <= P_ADDR;
            end
          endcase
        end
        // queue zero in-degree nodes in index order
        S_SCAN: begin
          if (ph_q == P_ADDR) begin
            ph_q <= P_NODE;
          end else begin
            if (node_rd_q == '0) qt_q <= qt_q + 1'b1;
            ph_q <= P_ADDR;
            if (node_q == n_q) state_q <= S_ORD_NODE;
            else node_q <= node_q + 7'd1;
          end
        end
        S_ORD_NODE: begin
          eptr_q <= '0;
          ph_q <= P_ADDR;
          if (qh_q == qt_q) begin
            reach_q <= src_ok ? (NN'(1) << (source_node_q - 7'd1)) : '0;
            qh_q <= '0;
            state_q <= S_REL_NODE;
          end else begin
            qh_q <= qh_q + 1'b1;
            state_q <= S_ORD_FETCH;
          end
        end
        S_ORD_FETCH: begin
          cur_q <= queue_rd_q;
          state_q <= S_ORD_EDGE;
        end
        // walk the current node's edges, release heads
        S_ORD_EDGE: begin
          unique case (ph_q)
            P_ADDR: begin
              if (walk_more) ph_q <= P_EDGE;
              else state_q <= S_ORD_NODE;
            end
            P_EDGE: begin
              if (edge_own) begin
                ph_q <= P_NODE;
              end else begin
                eptr_q <= eptr_q + 1'b1;
                ph_q <= P_ADDR;
              end
            end
            default: begin
              if (node_rd_q == AW'(1) && qt_q < QW'(NN)) qt_q <= qt_q + 1'b1;
              eptr_q <= eptr_q + 1'b1;
              ph_q <= P_ADDR;
            end
          endcase
        end
        S_REL_NODE: begin
          eptr_q <= '0;
          ph_q <= P_ADDR;
          if (qh_q == qt_q) begin
            node_q <= 7'd1;
            state_q <= S_EMIT;
          end else begin
            qh_q <= qh_q + 1'b1;
            state_q <= S_REL_FETCH;
          end
        end
        // skip nodes not yet reached, else fetch their distance
        S_REL_FETCH: begin
          cur_q <= queue_rd_q;
          if (reach_q[IW'(queue_rd_q - 7'd1)]) state_q <= S_REL_LOAD;
          else state_q <= S_REL_NODE;
        end
        S_REL_LOAD: begin
          cur_dist_q <= node_rd_s;
          state_q <= S_REL_EDGE;
        end
        // relax out edges; cur_dist_q tracks self-loop updates
        S_REL_EDGE: begin
          unique case (ph_q)
            P_ADDR: begin
              if (walk_more) ph_q <= P_EDGE;
              else state_q <= S_REL_NODE;
            end
            P_EDGE: begin
              if (edge_own) begin
                ph_q <= P_NODE;
              end else begin
                eptr_q <= eptr_q + 1'b1;
                ph_q <= P_ADDR;
              end
            end
            default: begin
              if (relax_upd) begin
                reach_q[rh] <= 1'b1;
                if (rh == ci) cur_dist_q <= cand;
              end
              eptr_q <= eptr_q + 1'b1;
              ph_q <= P_ADDR;
            end
          endcase
        end
        // one result per node, waits on the output register
        S_EMIT: begin
          if (ph_q == P_ADDR) begin
            ph_q <= P_NODE;
          end else if (emit_load) begin
            ph_q <= P_ADDR;
            if (node_q == n_q) begin
              edge_total_q <= '0;
              overflow_q <= 1'b0;
              state_q <= S_LOAD;
            end else begin
              node_q <= node_q + 7'd1;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign out_valid_o = ovalid_q;
  assign node_index_o = oidx_q;
  assign reachable_o = oreach_q;
  assign distance_o = odist_q;
  assign edges_dropped_o = odrop_q;
  assign last_o = olast_q;

`ifndef NO_ASSERTIONS
  a_store_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_total_q <= CW'(dlp_pkg::MaxEdges)) else $error("edge count overflow");
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qh_q <= qt_q) else $error("queue head passed tail");
  a_no_input_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LOAD) |-> !in_ready_o) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
    (out_valid_o && $stable(node_index_o) && $stable(distance_o)))
    else $error("result changed while waiting");
`endif
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
module tb;

  typedef struct {
    logic             mode;
    logic [6:0]       tail;
    logic [6:0]       head;
    logic [31:0]      weight;
  } graph_item_t;

  typedef struct {
    logic [6:0]       node;
    logic             reached;
    logic [37:0]      dist_val;
    logic             dropped;
    logic             last;
  } node_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic mode_i = dlp_pkg::ModeEdge;
  logic [6:0] from_node_i = '0;
  logic [6:0] to_node_i = '0;
  logic signed [31:0] weight_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [6:0] node_index_o;
  logic reachable_o;
  logic signed [37:0] distance_o;
  logic edges_dropped_o;
  logic last_o;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = dlp_pkg::CfgNodeCount;
  logic [6:0] cfg_data_i = '0;

  graph_item_t  pending_items[$];
  node_result_t expected_dists[$];

  // predictor copy of the block state
  logic [6:0]  held_tail[dlp_pkg::MaxEdges];
  logic [6:0]  held_head[dlp_pkg::MaxEdges];
  logic [31:0] held_weight[dlp_pkg::MaxEdges];
  int          held_edges = 0;
  bit          held_overflow = 1'b0;
  logic [6:0]  nodes_cfg = 7'd64;
  logic [6:0]  source_cfg = 7'd1;

  bit in_taken = 1'b0;
  bit calm = 1'b0;
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int computes = 0;

  dag_longest_path u_dut (.*);

  always #1 clk_i = ~clk_i;

  // longest-path prediction for one compute transfer
  function automatic void predict_distances();
    int n, qh, qt, u, v;
    int deg[dlp_pkg::MaxNodes+1];
    int order[dlp_pkg::MaxNodes];
    bit reached[dlp_pkg::MaxNodes+1];
    longint path_len[dlp_pkg::MaxNodes+1];
    longint cand;
    node_result_t r;
    n = nodes_cfg;
    if (n < 1) n = 1;
    if (n > dlp_pkg::MaxNodes) n = dlp_pkg::MaxNodes;
    foreach (deg[i]) begin
      deg[i] = 0;
      reached[i] = 1'b0;
      path_len[i] = 0;
    end
    for (int e = 0; e < held_edges; e++)
      if (held_tail[e] <= n && held_head[e] <= n) deg[held_head[e]]++;
    qt = 0;
    for (int i = 1; i <= n; i++)
      if (deg[i] == 0) begin
        order[qt] = i;
        qt++;
      end
    qh = 0;
    while (qh < qt) begin
      u = order[qh];
      qh++;
      for (int e = 0; e < held_edges; e++) begin
        v = held_head[e];
        if (held_tail[e] == u && v <= n && deg[v] > 0) begin
          deg[v]--;
          if (deg[v] == 0 && qt < dlp_pkg::MaxNodes) begin
            order[qt] = v;
            qt++;
          end
        end
      end
    end
    if (source_cfg >= 1 && source_cfg <= n) reached[source_cfg] = 1'b1;
    for (int k = 0; k < qt; k++) begin
      u = order[k];
      if (reached[u]) begin
        for (int e = 0; e < held_edges; e++) begin
          v = held_head[e];
          if (held_tail[e] == u && v <= n) begin
            cand = path_len[u] + longint'($signed(held_weight[e]));
            if (!reached[v] || cand > path_len[v]) begin
              path_len[v] = cand;
              reached[v] = 1'b1;
            end
          end
        end
      end
    end
    for (int i = 1; i <= n; i++) begin
      r.node = i[6:0];
      r.reached = reached[i];
      r.dist_val = reached[i] ? path_len[i][37:0] : '1;
      r.dropped = held_overflow;
      r.last = (i == n);
      expected_dists = {expected_dists, r};
    end
    held_edges = 0;
    held_overflow = 1'b0;
    computes++;
  endfunction

  function automatic void store_edge(graph_item_t it);
    if (it.tail < 1 || it.tail > dlp_pkg::MaxNodes || it.head < 1 ||
        it.head > dlp_pkg::MaxNodes) return;
    if (held_edges >= dlp_pkg::MaxEdges) begin
      held_overflow = 1'b1;
      return;
    end
    held_tail[held_edges] = it.tail;
    held_head[held_edges] = it.head;
    held_weight[held_edges] = it.weight;
    held_edges++;
  endfunction

  // input driver, changes at the falling edge
  always @(negedge clk_i) begin
    graph_item_t it;
    if (!in_valid_i || in_taken) begin
      in_taken = 1'b0;
      if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 6)) begin
        it = pending_items.pop_front();
        in_valid_i <= 1'b1;
        mode_i <= it.mode;
        from_node_i <= it.tail;
        to_node_i <= it.head;
        weight_i <= it.weight;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= calm || $urandom_range(99) >= 6;
  end

  // monitor: result check, then prediction of accepted transfers
  always @(posedge clk_i) begin
    node_result_t exp_r;
    graph_item_t it;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_dists.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result for node %0d", node_index_o);
      end else begin
        exp_r = expected_dists.pop_front();
        if (node_index_o !== exp_r.node || reachable_o !== exp_r.reached ||
            distance_o !== exp_r.dist_val || edges_dropped_o !== exp_r.dropped ||
            last_o !== exp_r.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp node %0d reach %0b dist %0d drop %0b last %0b / got %0d %0b %0d %0b %0b",
                     exp_r.node, exp_r.reached, $signed(exp_r.dist_val), exp_r.dropped,
                     exp_r.last, node_index_o, reachable_o, distance_o, edges_dropped_o,
                     last_o);
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      in_taken = 1'b1;
      items_sent++;
      it.mode = mode_i;
      it.tail = from_node_i;
      it.head = to_node_i;
      it.weight = weight_i;
      if (it.mode == dlp_pkg::ModeCompute) predict_distances();
      else store_edge(it);
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [6:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == dlp_pkg::CfgNodeCount) nodes_cfg = val;
    else source_cfg = val;
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid_i || expected_dists.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic add_edge(input logic [6:0] t, input logic [6:0] h, input logic [31:0] w);
    graph_item_t it;
    it.mode = dlp_pkg::ModeEdge;
    it.tail = t;
    it.head = h;
    it.weight = w;
    pending_items = {pending_items, it};
  endtask

  task automatic add_compute();
    graph_item_t it;
    it.mode = dlp_pkg::ModeCompute;
    it.tail = 7'($urandom);
    it.head = 7'($urandom);
    it.weight = $urandom;
    pending_items = {pending_items, it};
  endtask

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(20) - 10;
      default: return $urandom;
    endcase
  endfunction

  // random graph, mostly forward edges over the active node range, some backward or invalid
  task automatic queue_graph(input int n, input int edges);
    int t, h, hi;
    hi = (n < 1) ? 1 : (n > dlp_pkg::MaxNodes ? dlp_pkg::MaxNodes : n);
    for (int k = 0; k < edges; k++) begin
      case ($urandom_range(19))
        0: add_edge($urandom_range(1) ? 7'd0 : 7'($urandom_range(127, 65)),
                    7'($urandom_range(1, 64)), pick_weight());
        1: add_edge(7'($urandom_range(1, hi)), $urandom_range(1) ? 7'd0 : 7'd127,
                    pick_weight());
        2, 3: begin
          h = $urandom_range(1, hi);
          t = $urandom_range(h, hi);
          add_edge(t[6:0], h[6:0], pick_weight());
        end
        4: add_edge(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)), pick_weight());
        default: begin
          t = $urandom_range(1, hi);
          h = (t < hi) ? $urandom_range(t + 1, hi) : t;
          add_edge(t[6:0], h[6:0], pick_weight());
        end
      endcase
    end
    add_compute();
  endtask

  initial begin
    int n, src, phase;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, ignored nodes, cycle, unreached branch
    add_edge(7'd1, 7'd2, 32'h7fff_ffff);
    add_edge(7'd2, 7'd3, 32'h8000_0000);
    add_edge(7'd1, 7'd3, 32'hffff_ffff);
    add_edge(7'd0, 7'd5, 32'd7);
    add_edge(7'd65, 7'd3, 32'd7);
    add_edge(7'd3, 7'd127, 32'd7);
    add_edge(7'd5, 7'd6, 32'd4);
    add_edge(7'd6, 7'd5, 32'd4);
    add_edge(7'd3, 7'd5, 32'd9);
    add_edge(7'd4, 7'd7, 32'd1);
    add_edge(7'd1, 7'd64, 32'h7fff_ffff);
    add_edge(7'd64, 7'd63, 32'h7fff_ffff);
    add_compute();
    wait_idle();
    write_reg(dlp_pkg::CfgNodeCount, 7'd1);
    write_reg(dlp_pkg::CfgSourceNode, 7'd1);
    add_edge(7'd1, 7'd1, 32'd5);
    add_edge(7'd1, 7'd2, 32'd5);
    add_compute();
    add_compute();
    wait_idle();

    // random phases over several register settings
    phase = 0;
    while (items_sent < 215) begin
      calm = (phase >= 4 && phase < 8);
      case ($urandom_range(9))
        0: n = 64;
        1: n = 1;
        2: n = 0;
        3: n = $urandom_range(127, 65);
        default: n = $urandom_range(2, 10);
      endcase
      case ($urandom_range(7))
        0: src = 0;
        1: src = $urandom_range(127, (n < 64 ? n : 64) + 1);
        default: src = $urandom_range(1, (n < 1) ? 1 : (n > 64 ? 64 : n));
      endcase
      write_reg(dlp_pkg::CfgNodeCount, n[6:0]);
      write_reg(dlp_pkg::CfgSourceNode, src[6:0]);
      queue_graph(n, $urandom_range(0, (n >= 2 && n <= 10) ? 14 : 8));
      wait_idle();
      phase++;
    end

    $display("%0d transfers in, %0d computes, %0d node results checked over %0d phases",
             items_sent, computes, results_seen, phase);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timed out");
    $display("FAIL");
    $finish;
  end
endmodule
